@@ hdl/vaxrot_pkg.sv @@
package vaxrot_pkg;

  // Coordinate format: signed fixed point, COORD_WIDTH bits wide
  localparam int COORD_WIDTH = 32;

  // Default fraction bits of the sine and cosine coefficients
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION_AXIS = 1'b0,
    CFG_ANGLE_DEGREES = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  // Item payloads
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;
    logic                          last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
    logic                          last_out;
  } out_item_t;

  // Quarter-wave sine table, 0..90 degrees, unsigned Q1.30 (at most 2^30)
  localparam int          SIN_ENTRIES = 91;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef logic [30:0] sin_tab_t [SIN_ENTRIES];
  typedef logic [63:0] div_tab_t [1:10];

  // Divisors (2i)(2i+1) of the Taylor series terms
  localparam div_tab_t SERIES_DIV = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Evaluate the sine series for every whole degree at elaboration
  function automatic sin_tab_t sin_q30_table();
    sin_tab_t           tab;
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] prod;
    logic signed [63:0] sum;
    for (int k = 0; k < SIN_ENTRIES; k++) begin
      x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      prod = x * x;
      x2   = prod >> 30;
      term = x;
      sum  = $signed(x);
      for (int i = 1; i <= 10; i++) begin
        prod = term * x2;
        term = (prod >> 30) / SERIES_DIV[i];
        if ((i % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > $signed(ONE_Q30)) begin
        sum = $signed(ONE_Q30);
      end
      tab[k] = sum[30:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_Q30 = sin_q30_table();

endpackage

@@ hdl/vertex_axis_rotation_unit.sv @@
// An accepted item passes the registered stages select, multiply, sum and saturate to out_valid_o.
// Throughput: one item per cycle while the output is not stalled; the four product multipliers sit in their own stage.
// A stalled output holds each stage that is full; empty stages still take items.
// Reset (rst_ni low) empties the pipeline and sets the axis to x and the angle to 0.
// The sine and cosine registers follow an angle write through angle_q and then sin_q and cos_q.
module vertex_axis_rotation_unit #(
  parameter int TRIG_FRAC_BITS = vaxrot_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  vaxrot_pkg::in_item_t                in_data_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output vaxrot_pkg::out_item_t               out_data_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [vaxrot_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vaxrot_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import vaxrot_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int TW = TRIG_FRAC_BITS;
  localparam int KW = TW + 2;          // signed coefficient width
  localparam int PW = CW + KW;         // product width
  localparam int SW = PW + 1;          // sum width
  localparam int RW = CW + 2;          // rounded sum width

  localparam logic [31:0]          TRIG_HALF = 32'd1 << (29 - TW);
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (TW - 1);
  localparam logic signed [RW-1:0] SAT_MAX = RW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - RW'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  axis_e                   axis_q;
  logic signed [9:0]       angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= AXIS_X;
      angle_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATION_AXIS: axis_q  <= axis_e'(cfg_wdata_i[1:0]);
        CFG_ANGLE_DEGREES: angle_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sine and cosine of the configured angle
  // ---------------------------------------------------------------------------
  logic signed [10:0] ang_red;
  logic        [8:0]  ang_mod;
  logic        [1:0]  quad;
  logic        [8:0]  off_full;
  logic        [6:0]  off;
  logic        [31:0] sin_rnd;
  logic        [31:0] cos_rnd;
  logic signed [KW-1:0] sin_m;
  logic signed [KW-1:0] cos_m;
  logic signed [KW-1:0] sin_d;
  logic signed [KW-1:0] cos_d;
  logic signed [KW-1:0] sin_q;
  logic signed [KW-1:0] cos_q;

  // Reduce the angle into 0..359
  always_comb begin
    ang_red = {angle_q[9], angle_q};
    if (ang_red < 0) begin
      ang_red = ang_red + 11'sd360;
    end
    if (ang_red < 0) begin
      ang_red = ang_red + 11'sd360;
    end
    if (ang_red >= 11'sd360) begin
      ang_red = ang_red - 11'sd360;
    end
    ang_mod = ang_red[8:0];
  end

  // Fold into a quadrant and an offset of 0..89 degrees
  always_comb begin
    if (ang_mod < 9'd90) begin
      quad     = 2'd0;
      off_full = ang_mod;
    end else if (ang_mod < 9'd180) begin
      quad     = 2'd1;
      off_full = ang_mod - 9'd90;
    end else if (ang_mod < 9'd270) begin
      quad     = 2'd2;
      off_full = ang_mod - 9'd180;
    end else begin
      quad     = 2'd3;
      off_full = ang_mod - 9'd270;
    end
    off = off_full[6:0];
  end

  // Look up and round to the coefficient precision, half up
  always_comb begin
    sin_rnd = {1'b0, SIN_Q30[off]} + TRIG_HALF;
    cos_rnd = {1'b0, SIN_Q30[7'd90 - off]} + TRIG_HALF;
    sin_m   = $signed({1'b0, sin_rnd[30-TW +: TW+1]});
    cos_m   = $signed({1'b0, cos_rnd[30-TW +: TW+1]});
  end

  // Apply the quadrant signs
  always_comb begin
    case (quad)
      2'd0: begin
        sin_d = sin_m;
        cos_d = cos_m;
      end
      2'd1: begin
        sin_d = cos_m;
        cos_d = -sin_m;
      end
      2'd2: begin
        sin_d = -sin_m;
        cos_d = -cos_m;
      end
      default: begin
        sin_d = -cos_m;
        cos_d = sin_m;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q <= '0;
      cos_q <= KW'(1) <<< TW;
    end else begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: a stage advances when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, en4;

  assign en4        = !out_valid_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        out_valid_q <= v3_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick the two coordinates of the rotated plane
  // ---------------------------------------------------------------------------
  in_item_t             item1_q, item2_q, item3_q;
  axis_e                axis1_q, axis2_q, axis3_q;
  logic signed [CW-1:0] a_d, b_d, a1_q, b1_q;

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        a_d = in_data_i.y_in;
        b_d = in_data_i.z_in;
      end
      AXIS_Y: begin
        a_d = in_data_i.x_in;
        b_d = in_data_i.z_in;
      end
      default: begin
        a_d = in_data_i.x_in;
        b_d = in_data_i.y_in;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      item1_q <= in_data_i;
      axis1_q <= axis_q;
      a1_q    <= a_d;
      b1_q    <= b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the four exact products
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] p_ac_q, p_bs_q, p_as_q, p_bc_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      item2_q <= item1_q;
      axis2_q <= axis1_q;
      p_ac_q  <= PW'(a1_q) * PW'(cos_q);
      p_bs_q  <= PW'(b1_q) * PW'(sin_q);
      p_as_q  <= PW'(a1_q) * PW'(sin_q);
      p_bc_q  <= PW'(b1_q) * PW'(cos_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum and round to nearest, halves up
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [RW-1:0] rnd_a_q, rnd_b_q;

  assign sum_a = SW'(p_ac_q) - SW'(p_bs_q) + ROUND_HALF;
  assign sum_b = SW'(p_as_q) + SW'(p_bc_q) + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      item3_q <= item2_q;
      axis3_q <= axis2_q;
      rnd_a_q <= $signed(sum_a[TW +: RW]);
      rnd_b_q <= $signed(sum_b[TW +: RW]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: saturate and place the results back in the vertex
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] sat_a, sat_b;
  out_item_t            out_d, out_data_q;

  always_comb begin
    if (rnd_a_q > SAT_MAX) begin
      sat_a = SAT_MAX[CW-1:0];
    end else if (rnd_a_q < SAT_MIN) begin
      sat_a = SAT_MIN[CW-1:0];
    end else begin
      sat_a = rnd_a_q[CW-1:0];
    end
    if (rnd_b_q > SAT_MAX) begin
      sat_b = SAT_MAX[CW-1:0];
    end else if (rnd_b_q < SAT_MIN) begin
      sat_b = SAT_MIN[CW-1:0];
    end else begin
      sat_b = rnd_b_q[CW-1:0];
    end
  end

  always_comb begin
    out_d.x_out    = item3_q.x_in;
    out_d.y_out    = item3_q.y_in;
    out_d.z_out    = item3_q.z_in;
    out_d.last_out = item3_q.last_in;
    case (axis3_q)
      AXIS_X: begin
        out_d.y_out = sat_a;
        out_d.z_out = sat_b;
      end
      AXIS_Y: begin
        out_d.x_out = sat_a;
        out_d.z_out = sat_b;
      end
      AXIS_Z: begin
        out_d.x_out = sat_a;
        out_d.y_out = sat_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ tb/sv/vertex_axis_rotation_unit_test.sv @@
`timescale 1ns / 100ps

module vertex_axis_rotation_unit_test;
  import vaxrot_pkg::*;

  localparam int          TRIG_FB         = TRIG_FRAC_BITS_DEF;
  localparam logic [63:0] SINE_PI_Q30     = 64'd3373259426;
  localparam longint      UNIT_Q30        = 64'sd1 <<< 30;
  localparam longint      COORD_MAX       = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam longint      COORD_MIN       = -COORD_MAX - 64'sd1;
  localparam int          PIPE_LATENCY    = 4;
  localparam int          SETTLE_CYCLES   = 2;
  localparam int          IDLE_PCT        = 37;
  localparam int          NUM_PHASES      = 10;
  localparam int          ITEMS_PER_PHASE = 105;
  localparam int          CALM_PHASE      = 5;
  localparam int          HOLD_PHASE      = 7;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          MAX_REPORTS     = 10;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // One directed vertex with the rotation it runs under
  typedef struct {
    axis_e                   ax;
    logic signed [9:0]       ang;
    in_item_t                vin;
    bit                      typed;
    out_item_t               vout;
  } probe_t;

  probe_t            probes [$];
  out_item_t         rotated_q [$];
  axis_e             cur_axis      = AXIS_X;
  logic signed [9:0] cur_angle     = '0;
  int                idle_pct      = IDLE_PCT;
  bit                hold_off_go   = 1'b0;
  bit                hold_off_done = 1'b0;
  int                fault_cnt     = 0;
  int unsigned       cycle_cnt     = 0;

  vertex_axis_rotation_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sin(deg) for deg in 0..90 from the truncated Taylor series, rounded to Q1.14
  function automatic longint sine_q14(input int deg);
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] term;
    longint      acc;
    ang  = (64'(deg) * SINE_PI_Q30 + 64'd90) / 64'd180;
    sq   = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int i = 1; i <= 10; i++) begin
      term = ((term * sq) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > UNIT_Q30) acc = UNIT_Q30;
    return (acc + (64'sd1 <<< (29 - TRIG_FB))) >>> (30 - TRIG_FB);
  endfunction

  // Round a*ca + b*cb back to coordinate scale, halves upward, then saturate
  function automatic longint plane_mix(input longint a, input longint ca,
                                       input longint b, input longint cb);
    longint acc;
    acc = (a * ca + b * cb + (64'sd1 <<< (TRIG_FB - 1))) >>> TRIG_FB;
    if (acc > COORD_MAX) acc = COORD_MAX;
    if (acc < COORD_MIN) acc = COORD_MIN;
    return acc;
  endfunction

  // Expected output for one vertex under the given axis and angle
  function automatic out_item_t rotate_vertex(input in_item_t v, input axis_e ax,
                                              input logic signed [9:0] ang);
    longint    crd [3];
    longint    sm, cm, sn, cs, a, b;
    int        red, quad, off, ia, ib;
    out_item_t o;
    crd[0] = longint'($signed(v.x_in));
    crd[1] = longint'($signed(v.y_in));
    crd[2] = longint'($signed(v.z_in));
    // fold the angle into a quadrant and an offset within it
    red = int'(ang) % 360;
    if (red < 0) red = red + 360;
    quad = red / 90;
    off  = red % 90;
    sm   = sine_q14(off);
    cm   = sine_q14(90 - off);
    case (quad)
      0: begin
        sn = sm;
        cs = cm;
      end
      1: begin
        sn = cm;
        cs = -sm;
      end
      2: begin
        sn = -sm;
        cs = -cm;
      end
      default: begin
        sn = -cm;
        cs = sm;
      end
    endcase
    if (ax != AXIS_NONE) begin
      ia      = (ax == AXIS_X) ? 1 : 0;
      ib      = (ax == AXIS_Z) ? 1 : 2;
      a       = crd[ia];
      b       = crd[ib];
      crd[ia] = plane_mix(a, cs, b, -sn);
      crd[ib] = plane_mix(a, sn, b, cs);
    end
    o.x_out    = 32'(crd[0]);
    o.y_out    = 32'(crd[1]);
    o.z_out    = 32'(crd[2]);
    o.last_out = v.last_in;
    return o;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_row(input axis_e ax, input logic signed [9:0] ang,
                         input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                         input logic last, input bit typed,
                         input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez);
    probe_t row;
    row.ax    = ax;
    row.ang   = ang;
    row.vin   = '{x_in: x, y_in: y, z_in: z, last_in: last};
    row.typed = typed;
    row.vout  = '{x_out: ex, y_out: ey, z_out: ez, last_out: last};
    probes.push_back(row);
  endtask

  task automatic note_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offer one item, with a random gap first, and log its expected result on acceptance
  task automatic send_item(input in_item_t it, input out_item_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    rotated_q.push_back(want);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input axis_e ax, input logic signed [9:0] ang);
    drain();
    write_reg(CFG_ROTATION_AXIS, CFG_DATA_W'(ax));
    write_reg(CFG_ANGLE_DEGREES, ang);
    cur_axis  = ax;
    cur_angle = ang;
    // give the sine and cosine registers time to follow the new angle
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus: directed table, then random phases under changing rotations
  initial begin : stimulus
    in_item_t          it;
    out_item_t         want;
    axis_e             ax;
    logic signed [9:0] ang;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ROTATION_AXIS;
    cfg_wdata_i = '0;

    // identity after reset
    add_row(AXIS_X, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0, 1'b1,
            32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    add_row(AXIS_X, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(AXIS_X, 0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
    // no axis selected: vertex passes through
    add_row(AXIS_NONE, 90, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
            32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    // right angles give exact swaps and negations, with saturation of -min
    add_row(AXIS_Z, 90, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b1,
            32'hFFFE_0000, 32'h0001_0000, 32'h0003_0000);
    add_row(AXIS_Z, 180, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 1'b1, 1'b1,
            32'h7FFF_FFFF, 32'h8000_0001, 32'h5555_5555);
    add_row(AXIS_X, 270, 32'h1111_1111, 32'h0005_0000, 32'hFFFD_0000, 1'b0, 1'b1,
            32'h1111_1111, 32'hFFFD_0000, 32'hFFFB_0000);
    add_row(AXIS_Y, -90, 32'h0004_0000, 32'h2222_2222, 32'h8000_0000, 1'b1, 1'b1,
            32'h8000_0000, 32'h2222_2222, 32'hFFFC_0000);
    // full turns either way
    add_row(AXIS_Y, 360, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b1,
            32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    add_row(AXIS_Y, -360, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1,
            32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    // oblique angles, extreme inputs and angles past one turn
    add_row(AXIS_Z, 45, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, '0, '0, '0);
    add_row(AXIS_Z, 45, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0, '0);
    add_row(AXIS_X, 1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0, '0, '0);
    add_row(AXIS_X, 89, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0, '0);
    add_row(AXIS_Y, 511, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, 1'b0, '0, '0, '0);
    add_row(AXIS_Y, -512, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0,
            '0, '0, '0);
    add_row(AXIS_Z, 450, 32'h0003_8000, 32'hFFFE_4000, 32'h0, 1'b0, 1'b0, '0, '0, '0);
    add_row(AXIS_Z, -1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b1, 1'b0, '0, '0, '0);
    add_row(AXIS_X, 359, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0, '0);
    add_row(AXIS_NONE, -512, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 1'b0, 1'b1,
            32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
    add_row(AXIS_Z, 135, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_F00D, 1'b1, 1'b0,
            '0, '0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table, reconfiguring only when the rotation changes
    foreach (probes[i]) begin
      if (probes[i].ax != cur_axis || probes[i].ang != cur_angle) begin
        set_config(probes[i].ax, probes[i].ang);
      end
      want = probes[i].typed ? probes[i].vout
                             : rotate_vertex(probes[i].vin, cur_axis, cur_angle);
      send_item(probes[i].vin, want);
    end

    // random phases: extreme angles first, then random axis and angle
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        ax = axis_e'(p);
        case (p)
          0:       ang = -360;
          1:       ang = 360;
          2:       ang = 511;
          default: ang = -512;
        endcase
      end else begin
        ax  = axis_e'($urandom_range(0, 3));
        ang = 10'($urandom_range(0, 1023));
      end
      set_config(ax, ang);
      idle_pct = (p == CALM_PHASE || p == HOLD_PHASE) ? 0 : IDLE_PCT;
      if (p == HOLD_PHASE) hold_off_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.x_in    = pick_coord();
        it.y_in    = pick_coord();
        it.z_in    = pick_coord();
        it.last_in = ($urandom_range(0, 7) == 0);
        send_item(it, rotate_vertex(it, cur_axis, cur_angle));
      end
    end

    drain();
    if (fault_cnt == 0) begin
      $display("vertex_axis_rotation_unit test passed");
    end else begin
      $display("vertex_axis_rotation_unit test failed");
    end
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off to fill the pipeline
  initial begin : sink
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready_i <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // Compare each accepted item with the oldest expected rotation
  always @(posedge clk_i) begin : check_out
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rotated_q.size() == 0) begin
        note_fault($sformatf("unexpected item x=%h y=%h z=%h last=%b",
                             out_data_o.x_out, out_data_o.y_out, out_data_o.z_out,
                             out_data_o.last_out));
      end else begin
        want = rotated_q.pop_front();
        if (out_data_o.x_out !== want.x_out || out_data_o.y_out !== want.y_out ||
            out_data_o.z_out !== want.z_out || out_data_o.last_out !== want.last_out) begin
          note_fault($sformatf(
            "mismatch: expected x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
            want.x_out, want.y_out, want.z_out, want.last_out,
            out_data_o.x_out, out_data_o.y_out, out_data_o.z_out, out_data_o.last_out));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("vertex_axis_rotation_unit test failed");
      $finish;
    end
  end

endmodule
